FILE: src/tsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants for trajectory smoothing correction
// Field widths, window and ring sizing, the job record passed from the front
// end to the back end, and the ring index helper.
// ----------------------------------------------------------------------------
package tsc_pkg;

  // Window radius and trajectory ring size (ring must hold 2*RADIUS+2 frames)
  localparam int RADIUS      = 30;
  localparam int RING_DEPTH  = 64;

  // Payload field widths
  localparam int DX_W        = 24;
  localparam int DA_W        = 19;
  localparam int DA_LIM      = 205887;

  // Internal widths
  localparam int NCH         = 3;
  localparam int TRAJ_W      = 32;
  localparam int SUM_W       = 40;
  localparam int DIFF_W      = SUM_W + 1;
  localparam int FRAME_W     = 32;
  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int OFF_W       = RING_AW + 1;
  localparam int FILL_W      = $clog2(2 * RADIUS + 2);
  localparam int CNT_W       = FILL_W;
  localparam int M_W         = $clog2(RADIUS + 1);
  localparam int FILL_CAP    = 2 * RADIUS + 1;

  // Divider: quotient bits retired per cycle
  localparam int DIV_BITS    = 8;
  localparam int DIV_STEPS   = SUM_W / DIV_BITS;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  // Job queue between front and back end
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // Channel lanes
  localparam int CH_X = 0;
  localparam int CH_Y = 1;
  localparam int CH_A = 2;

  // Output saturation limits per lane
  localparam logic signed [DIFF_W-1:0] LIM_HI [NCH] = '{
    DIFF_W'(2 ** (DX_W - 1) - 1), DIFF_W'(2 ** (DX_W - 1) - 1), DIFF_W'(DA_LIM)};
  localparam logic signed [DIFF_W-1:0] LIM_LO [NCH] = '{
    DIFF_W'(-(2 ** (DX_W - 1))), DIFF_W'(-(2 ** (DX_W - 1))), DIFF_W'(-DA_LIM)};

  // One classified frame: new trajectory point, ring slot, frames before it (capped at FILL_CAP)
  typedef struct packed {
    logic [NCH-1:0][TRAJ_W-1:0] traj;
    logic [RING_AW-1:0]         ptr;
    logic [FILL_W-1:0]          fill;
    logic                       last;
  } job_t;

  // Divider status seen by the back end
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Ring slot k frames before slot ptr (k < RING_DEPTH)
  function automatic logic [RING_AW-1:0] ring_back(input logic [RING_AW-1:0] ptr,
                                                    input logic [OFF_W-1:0]   k);
    logic [OFF_W-1:0] t;
    t = {1'b0, ptr} + OFF_W'(RING_DEPTH) - k;
    if (t >= OFF_W'(RING_DEPTH)) begin
      t = t - OFF_W'(RING_DEPTH);
    end
    return t[RING_AW-1:0];
  endfunction

endpackage

FILE: src/tsc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_if: valid/ready channels of trajectory smoothing correction
// Input frame motion channel and corrected motion output channel.
// ----------------------------------------------------------------------------
interface tsc_in_if import tsc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [DX_W-1:0] dx;
  logic signed [DX_W-1:0] dy;
  logic signed [DA_W-1:0] da;
  logic                   is_last;

  modport source (output valid, dx, dy, da, is_last, input ready);
  modport sink   (input valid, dx, dy, da, is_last, output ready);
endinterface

interface tsc_out_if import tsc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [DX_W-1:0] new_dx;
  logic signed [DX_W-1:0] new_dy;
  logic signed [DA_W-1:0] new_da;
  logic                   end_mark;

  modport source (output valid, new_dx, new_dy, new_da, end_mark, input ready);
  modport sink   (input valid, new_dx, new_dy, new_da, end_mark, output ready);
endinterface

FILE: src/tsc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/tsc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_div: three-lane iterative rounding divider
// Divides each window sum by the frame count, rounding to nearest with ties
// away from zero. Restoring division, DIV_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
module tsc_div import tsc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NCH-1:0][SUM_W-1:0] sum,
  input  logic [CNT_W-1:0]        cnt,
  output div_stat_t               stat,
  output logic [NCH-1:0][SUM_W-1:0] quot
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  dvd      [NCH];
  logic [CNT_W-1:0]  rem      [NCH];
  logic              neg      [NCH];
  logic [SUM_W-1:0]  dvd_next [NCH];
  logic [CNT_W-1:0]  rem_next [NCH];

  // DIV_BITS restoring steps per lane per cycle; quotient bits shift into dvd
  always_comb begin
    logic [CNT_W:0]   t;
    logic [CNT_W-1:0] r;
    logic [SUM_W-1:0] d;
    for (int c = 0; c < NCH; c++) begin
      r = rem[c];
      d = dvd[c];
      for (int k = 0; k < DIV_BITS; k++) begin
        t = {r, d[SUM_W-1]};
        d = {d[SUM_W-2:0], 1'b0};
        if (t >= {1'b0, cnt_r}) begin
          t = t - {1'b0, cnt_r};
          d[0] = 1'b1;
        end
        r = t[CNT_W-1:0];
      end
      dvd_next[c] = d;
      rem_next[c] = r;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(DIV_STEPS - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // Datapath: load magnitude plus half the divisor, then iterate
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= cnt;
      for (int c = 0; c < NCH; c++) begin
        neg[c] <= sum[c][SUM_W-1];
        rem[c] <= '0;
        dvd[c] <= (sum[c][SUM_W-1] ? (~sum[c] + 1'b1) : sum[c])
                  + SUM_W'(cnt[CNT_W-1:1]);
      end
    end else if (busy) begin
      for (int c = 0; c < NCH; c++) begin
        dvd[c] <= dvd_next[c];
        rem[c] <= rem_next[c];
      end
    end
  end

  // Signed quotient
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      quot[c] = neg[c] ? (~dvd[c] + 1'b1) : dvd[c];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: src/tsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_front: frame intake and classification
// Accumulates motions into the saturating trajectory, tracks the frame count
// and ring slot of the sequence, and pushes one job per frame to the queue.
// ----------------------------------------------------------------------------
module tsc_front import tsc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  tsc_in_if.sink       frame_in,
  input  logic         q_full,
  output logic         q_push,
  output job_t         q_job
);

  logic [FRAME_W-1:0]   n;
  logic [RING_AW-1:0]   ptr;
  logic [TRAJ_W-1:0]    traj      [NCH];
  logic [TRAJ_W-1:0]    traj_next [NCH];
  logic [TRAJ_W:0]      delta     [NCH];
  logic [FRAME_W-1:0]   n_inc;

  assign frame_in.ready = !q_full;
  assign q_push         = frame_in.valid && !q_full;
  assign n_inc          = n + 1'b1;

  // Sign-extend motions to trajectory width plus one
  assign delta[CH_X] = {{(TRAJ_W + 1 - DX_W){frame_in.dx[DX_W-1]}}, frame_in.dx};
  assign delta[CH_Y] = {{(TRAJ_W + 1 - DX_W){frame_in.dy[DX_W-1]}}, frame_in.dy};
  assign delta[CH_A] = {{(TRAJ_W + 1 - DA_W){frame_in.da[DA_W-1]}}, frame_in.da};

  // Saturating trajectory update
  always_comb begin
    logic [TRAJ_W:0] s;
    for (int c = 0; c < NCH; c++) begin
      s = {traj[c][TRAJ_W-1], traj[c]} + delta[c];
      if (s[TRAJ_W] != s[TRAJ_W-1]) begin
        traj_next[c] = s[TRAJ_W] ? {1'b1, {(TRAJ_W - 1){1'b0}}}
                                 : {1'b0, {(TRAJ_W - 1){1'b1}}};
      end else begin
        traj_next[c] = s[TRAJ_W-1:0];
      end
    end
  end

  // Job record for the back end
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      q_job.traj[c] = traj_next[c];
    end
    q_job.ptr  = ptr;
    q_job.fill = (n >= FRAME_W'(FILL_CAP)) ? FILL_W'(FILL_CAP) : n[FILL_W-1:0];
    q_job.last = frame_in.is_last;
  end

  // Sequence state: a last frame starts over; a wrap resets n and ptr only
  always_ff @(posedge clk) begin
    if (rst) begin
      n   <= '0;
      ptr <= '0;
      for (int c = 0; c < NCH; c++) begin
        traj[c] <= '0;
      end
    end else if (q_push) begin
      if (frame_in.is_last) begin
        n   <= '0;
        ptr <= '0;
        for (int c = 0; c < NCH; c++) begin
          traj[c] <= '0;
        end
      end else begin
        n <= n_inc;
        if (n_inc == '0 || ptr == RING_AW'(RING_DEPTH - 1)) begin
          ptr <= '0;
        end else begin
          ptr <= ptr + 1'b1;
        end
        for (int c = 0; c < NCH; c++) begin
          traj[c] <= traj_next[c];
        end
      end
    end
  end

endmodule

FILE: src/tsc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_fifo: job queue between front and back end
// Small register FIFO so intake and correction stall independently.
// ----------------------------------------------------------------------------
module tsc_fifo import tsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t            mem [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [QC_W-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == QC_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: src/tsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_back: window sums, division and corrected motion output
// Writes each trajectory point into the ring, keeps the running window sums,
// and steps through at most one result (steady state) or the whole flush per job.
// ----------------------------------------------------------------------------
module tsc_back import tsc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  input  job_t     q_head,
  output logic     q_pop,
  tsc_out_if.source corr_out
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOAD = 7'b0000010,
    ST_SUB  = 7'b0000100,
    ST_PREV = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_EMIT = 7'b0100000,
    ST_FSUB = 7'b1000000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  job_t                      job;
  logic [M_W-1:0]            m;
  logic [M_W-1:0]            m_sel;
  logic [SUM_W-1:0]          wsum [NCH];
  logic [TRAJ_W-1:0]         prev [NCH];
  logic [TRAJ_W-1:0]         rd_t [NCH];
  logic [NCH-1:0][SUM_W-1:0] div_sum;
  logic [NCH-1:0][SUM_W-1:0] div_q;
  logic [CNT_W-1:0]          div_cnt;
  div_stat_t                 div_stat;
  logic                      div_start;
  logic [RING_AW-1:0]        raddr;
  logic [NCH*TRAJ_W-1:0]     rdata;
  logic                      ring_we;
  logic [FILL_W:0]           fill_x;
  logic [FILL_W:0]           m_r;
  logic [FILL_W:0]           cnt_min;
  logic                      has_sub;
  logic                      do_emit;
  logic                      flush_sub;
  logic                      has_prev;
  logic                      out_valid;
  logic                      out_load;
  logic [DIFF_W-1:0]         sat [NCH];

  // Trajectory ring
  tsc_ram #(
    .WIDTH (NCH * TRAJ_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (job.ptr),
    .wdata (job.traj),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Window mean
  tsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (div_sum),
    .cnt   (div_cnt),
    .stat  (div_stat),
    .quot  (div_q)
  );

  assign ring_we   = (state == ST_LOAD);
  assign div_start = (state == ST_PREV);
  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign out_load  = (state == ST_EMIT) && (!out_valid || corr_out.ready);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      rd_t[c]    = rdata[c*TRAJ_W +: TRAJ_W];
      div_sum[c] = wsum[c];
    end
  end

  // Window bookkeeping: m is how many frames the current result lags the job
  assign fill_x    = {1'b0, job.fill};
  assign m_r       = (FILL_W + 1)'(m) + (FILL_W + 1)'(RADIUS);
  assign cnt_min   = (fill_x < m_r) ? fill_x : m_r;
  assign div_cnt   = CNT_W'(cnt_min + 1'b1);
  assign has_sub   = (job.fill == FILL_W'(FILL_CAP));
  assign do_emit   = job.last || (job.fill >= FILL_W'(RADIUS));
  assign flush_sub = (fill_x >= m_r);
  assign has_prev  = (job.fill > FILL_W'(m));

  always_comb begin
    if (job.last && job.fill < FILL_W'(RADIUS)) begin
      m_sel = M_W'(job.fill);
    end else begin
      m_sel = M_W'(RADIUS);
    end
  end

  // Ring read address, data arrives in the following state
  always_comb begin
    unique case (state)
      ST_LOAD: raddr = ring_back(job.ptr, OFF_W'(FILL_CAP));
      ST_SUB:  raddr = ring_back(job.ptr, OFF_W'(m_sel) + OFF_W'(1));
      ST_EMIT: raddr = ring_back(job.ptr, OFF_W'(m) + OFF_W'(RADIUS));
      ST_FSUB: raddr = ring_back(job.ptr, OFF_W'(m));
      default: raddr = job.ptr;
    endcase
  end

  // Corrected motion: mean minus previous trajectory point, saturated
  always_comb begin
    logic [DIFF_W-1:0] diff;
    for (int c = 0; c < NCH; c++) begin
      diff = {div_q[c][SUM_W-1], div_q[c]}
             - {{(DIFF_W - TRAJ_W){prev[c][TRAJ_W-1]}}, prev[c]};
      if ($signed(diff) > LIM_HI[c]) begin
        sat[c] = LIM_HI[c];
      end else if ($signed(diff) < LIM_LO[c]) begin
        sat[c] = LIM_LO[c];
      end else begin
        sat[c] = diff;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!q_empty) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_SUB;
      ST_SUB:  state_next = do_emit ? ST_PREV : ST_IDLE;
      ST_PREV: state_next = ST_DIV;
      ST_DIV:  if (div_stat.done) state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_next = (job.last && m != '0) ? ST_FSUB : ST_IDLE;
        end
      end
      ST_FSUB: state_next = ST_PREV;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (corr_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          job <= q_head;
        end
      end
      ST_LOAD: begin
        // first frame of a sequence starts a fresh window
        for (int c = 0; c < NCH; c++) begin
          wsum[c] <= ((job.fill == '0) ? '0 : wsum[c])
                     + {{(SUM_W - TRAJ_W){job.traj[c][TRAJ_W-1]}}, job.traj[c]};
        end
      end
      ST_SUB: begin
        // drop the point that left the trailing edge of the window
        if (has_sub) begin
          for (int c = 0; c < NCH; c++) begin
            wsum[c] <= wsum[c] - {{(SUM_W - TRAJ_W){rd_t[c][TRAJ_W-1]}}, rd_t[c]};
          end
        end
        m <= m_sel;
      end
      ST_PREV: begin
        for (int c = 0; c < NCH; c++) begin
          prev[c] <= has_prev ? rd_t[c] : '0;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          corr_out.new_dx   <= sat[CH_X][DX_W-1:0];
          corr_out.new_dy   <= sat[CH_Y][DX_W-1:0];
          corr_out.new_da   <= sat[CH_A][DA_W-1:0];
          corr_out.end_mark <= job.last && (m == '0);
        end
      end
      ST_FSUB: begin
        // flush: window shrinks from the trailing edge only
        if (flush_sub) begin
          for (int c = 0; c < NCH; c++) begin
            wsum[c] <= wsum[c] - {{(SUM_W - TRAJ_W){rd_t[c][TRAJ_W-1]}}, rd_t[c]};
          end
        end
        m <= m - 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign corr_out.valid = out_valid;

`ifndef SYNTHESIS
  a_fsub_only_in_flush: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FSUB) |-> (job.last && m != '0))
    else $error("flush step outside a flush or past the final frame");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider finished while sequencer not waiting on it");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_emit_then_leave: assert property (@(posedge clk) disable iff (rst)
    (out_load && !job.last) |=> (state == ST_IDLE))
    else $error("steady-state job produced more than one result");
`endif

endmodule

FILE: src/trajectory_smoothing_correction.sv
`timescale 1ns / 1ps
// The result for frame i is computed once frame i+RADIUS is accepted: ring write,
// two ring reads, the divider and the output register, in that order.
// The back-end sequencer works on one job at a time and takes no new job until it
// is done with the current one; a last frame flushes up to RADIUS+1 results.
// A 2-entry job queue keeps input transfers going while the back end works.
// Reset: synchronous rst clears trajectory, counters and handshake state; no ring clear.
// ----------------------------------------------------------------------------
// trajectory_smoothing_correction: moving-average video stabilization
// Accumulates frame motions into a trajectory, smooths it with a centered,
// clipped moving average and outputs the corrected per-frame motion.
// ----------------------------------------------------------------------------
module trajectory_smoothing_correction import tsc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tsc_in_if.sink    frame_in,
  tsc_out_if.source corr_out
);

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  job_t push_job;
  job_t head_job;

  // Intake and classification
  tsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .frame_in (frame_in),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // Job queue
  tsc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Smoothing and correction
  tsc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (head_job),
    .q_pop    (q_pop),
    .corr_out (corr_out)
  );

endmodule

FILE: dv/tb_trajectory_smoothing_correction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trajectory_smoothing_correction: self-checking bench for trajectory
// smoothing correction
// Frame motions are queued by a stimulus process and sent by a clocked driver.
// A clocked monitor tracks the trajectory, predicts the corrected motion of
// each frame and checks every output transfer against the oldest prediction.
// Directed frames cover field extremes, single- and two-frame sequences, out of
// range angles and output saturation. Random sequences of mixed length follow,
// one of them long enough to saturate the trajectory. Both sides stall at
// random, and the sink holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_trajectory_smoothing_correction;
  import tsc_pkg::*;

  localparam int     RANDOM_ITEMS = 460;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     HOLD_AT      = 60;
  localparam longint XY_LIM       = 2 ** (DX_W - 1) - 1;
  localparam longint T_MAX        = 64'sd2147483647;
  localparam longint T_MIN        = -64'sd2147483648;

  localparam logic signed [DX_W-1:0] XY_MAX = {1'b0, {(DX_W - 1){1'b1}}};
  localparam logic signed [DX_W-1:0] XY_MIN = {1'b1, {(DX_W - 1){1'b0}}};
  localparam logic signed [DA_W-1:0] A_RAW_MAX = {1'b0, {(DA_W - 1){1'b1}}};
  localparam logic signed [DA_W-1:0] A_RAW_MIN = {1'b1, {(DA_W - 1){1'b0}}};

  typedef struct {
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic signed [DA_W-1:0] da;
    logic                   eos;
  } frame_t;

  typedef struct {
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic signed [DA_W-1:0] da;
    logic                   mark;
  } corr_t;

  logic clk;
  logic rst;

  tsc_in_if  frame_in ();
  tsc_out_if corr_out ();

  trajectory_smoothing_correction u_top (
    .clk      (clk),
    .rst      (rst),
    .frame_in (frame_in),
    .corr_out (corr_out)
  );

  frame_t pending_frames[$];
  corr_t  expected_corr[$];
  int     planned;
  int     frames_sent;
  int     fails;
  int     hold_left;
  bit     hold_done;

  // Trajectory tracking state
  int       traj_ring [NCH][RING_DEPTH];
  int       run_traj [NCH];
  bit [31:0] frame_no;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset and known input levels
  initial begin
    rst              = 1'b1;
    frame_in.valid   = 1'b0;
    frame_in.dx      = '0;
    frame_in.dy      = '0;
    frame_in.da      = '0;
    frame_in.is_last = 1'b0;
    corr_out.ready   = 1'b0;
    frames_sent      = 0;
    fails            = 0;
    hold_left        = 0;
    hold_done        = 1'b0;
    frame_no         = '0;
    run_traj         = '{default: 0};
    traj_ring        = '{default: '{default: 0}};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Idle percentage per side: sender light/sink heavy, then swapped, then none
  function automatic int stall_pct(input bit sink_side);
    if (frames_sent * 3 < planned) begin
      return sink_side ? 66 : 15;
    end else if (frames_sent * 3 < planned * 2) begin
      return sink_side ? 15 : 66;
    end
    return 0;
  endfunction

  // Rounded division, ties away from zero
  function automatic longint round_div(input longint s, input longint c);
    longint mag;
    longint q;
    mag = (s < 0) ? -s : s;
    q   = (mag + c / 2) / c;
    return (s < 0) ? -q : q;
  endfunction

  // Corrected motion of frame i with its window clipped at frame 'upto'
  task automatic emit_correction(input longint unsigned i, input longint unsigned upto,
                                 input bit mark);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned k;
    longint          cnt;
    longint          sum;
    longint          prev;
    longint          v;
    longint          lim_hi;
    longint          lim_lo;
    longint          vals [NCH];
    int              ch;
    corr_t           res;
    lo  = (i >= RADIUS) ? i - RADIUS : 0;
    hi  = (i + RADIUS <= upto) ? i + RADIUS : upto;
    cnt = longint'(hi - lo + 1);
    for (ch = 0; ch < NCH; ch++) begin
      sum = 0;
      for (k = lo; k <= hi; k++) begin
        sum += traj_ring[ch][k % RING_DEPTH];
      end
      prev   = (i > 0) ? longint'(traj_ring[ch][(i - 1) % RING_DEPTH]) : 0;
      v      = round_div(sum, cnt) - prev;
      lim_hi = (ch == CH_A) ? longint'(DA_LIM) : XY_LIM;
      lim_lo = (ch == CH_A) ? -longint'(DA_LIM) : -XY_LIM - 1;
      if (v > lim_hi) begin
        v = lim_hi;
      end else if (v < lim_lo) begin
        v = lim_lo;
      end
      vals[ch] = v;
    end
    res.dx   = DX_W'(vals[CH_X]);
    res.dy   = DX_W'(vals[CH_Y]);
    res.da   = DA_W'(vals[CH_A]);
    res.mark = mark;
    expected_corr.insert(expected_corr.size(), res);
  endtask

  // Accumulate one accepted frame and queue the corrections it releases
  task automatic accumulate_frame(input frame_t f);
    longint unsigned n;
    longint unsigned i;
    longint          d [NCH];
    longint          t;
    int              ch;
    n       = frame_no;
    d[CH_X] = f.dx;
    d[CH_Y] = f.dy;
    d[CH_A] = f.da;
    for (ch = 0; ch < NCH; ch++) begin
      t = longint'(run_traj[ch]) + d[ch];
      if (t > T_MAX) begin
        t = T_MAX;
      end else if (t < T_MIN) begin
        t = T_MIN;
      end
      run_traj[ch]                  = int'(t);
      traj_ring[ch][n % RING_DEPTH] = int'(t);
    end
    frame_no = frame_no + 1;
    if (!f.eos) begin
      if (n >= RADIUS) begin
        emit_correction(n - RADIUS, n, 1'b0);
      end
    end else begin
      // End of sequence: flush every pending frame, then restart
      for (i = (n >= RADIUS) ? n - RADIUS : 0; i <= n; i++) begin
        emit_correction(i, n, i == n);
      end
      run_traj = '{default: 0};
      frame_no = '0;
    end
  endtask

  // Driver: offers queued frames, with random gaps
  always @(posedge clk) begin : drive_frames
    frame_t nxt;
    if (rst) begin
      frame_in.valid <= 1'b0;
    end else begin
      if (frame_in.valid && frame_in.ready) begin
        frames_sent <= frames_sent + 1;
      end
      if (!frame_in.valid || frame_in.ready) begin
        if (pending_frames.size() != 0 && $urandom_range(0, 99) >= stall_pct(1'b0)) begin
          nxt = pending_frames.pop_front();
          frame_in.valid   <= 1'b1;
          frame_in.dx      <= nxt.dx;
          frame_in.dy      <= nxt.dy;
          frame_in.da      <= nxt.da;
          frame_in.is_last <= nxt.eos;
        end else begin
          frame_in.valid <= 1'b0;
        end
      end
    end
  end

  // Long sink hold-off, once, early in the run
  always @(posedge clk) begin
    if (!rst) begin
      if (!hold_done && frames_sent >= HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Monitor: check output transfers, track input transfers, drive ready
  always @(posedge clk) begin : watch_results
    corr_t  got;
    corr_t  want;
    frame_t seen;
    if (rst) begin
      corr_out.ready <= 1'b0;
    end else begin
      if (corr_out.valid && corr_out.ready) begin
        got.dx   = corr_out.new_dx;
        got.dy   = corr_out.new_dy;
        got.da   = corr_out.new_da;
        got.mark = corr_out.end_mark;
        if (expected_corr.size() == 0) begin
          $error("unexpected result: new_dx %0d new_dy %0d new_da %0d end_mark %0b",
                 got.dx, got.dy, got.da, got.mark);
          fails++;
        end else begin
          want = expected_corr.pop_front();
          if (got.dx !== want.dx) begin
            $error("new_dx mismatch: expected %0d, got %0d", want.dx, got.dx);
            fails++;
          end
          if (got.dy !== want.dy) begin
            $error("new_dy mismatch: expected %0d, got %0d", want.dy, got.dy);
            fails++;
          end
          if (got.da !== want.da) begin
            $error("new_da mismatch: expected %0d, got %0d", want.da, got.da);
            fails++;
          end
          if (got.mark !== want.mark) begin
            $error("end_mark mismatch: expected %0b, got %0b", want.mark, got.mark);
            fails++;
          end
        end
      end
      if (frame_in.valid && frame_in.ready) begin
        seen.dx  = frame_in.dx;
        seen.dy  = frame_in.dy;
        seen.da  = frame_in.da;
        seen.eos = frame_in.is_last;
        accumulate_frame(seen);
      end
      corr_out.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct(1'b1));
    end
  end

  // Stimulus helpers
  task automatic push_frame(input logic signed [DX_W-1:0] x, input logic signed [DX_W-1:0] y,
                            input logic signed [DA_W-1:0] a, input logic eos);
    frame_t f;
    f.dx  = x;
    f.dy  = y;
    f.da  = a;
    f.eos = eos;
    pending_frames.insert(pending_frames.size(), f);
  endtask

  function automatic logic signed [DX_W-1:0] rand_xy();
    case ($urandom_range(0, 7))
      0:       return XY_MAX;
      1:       return XY_MIN;
      2:       return DX_W'(int'($urandom_range(0, 1023)) - 512);
      default: return DX_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [DA_W-1:0] rand_angle();
    case ($urandom_range(0, 7))
      0:       return DA_W'(DA_LIM);
      1:       return DA_W'(-DA_LIM);
      2:       return DA_W'($urandom());
      default: return DA_W'(int'($urandom_range(0, 2 * DA_LIM)) - DA_LIM);
    endcase
  endfunction

  // One sequence; a drift sequence ramps hard to saturate the trajectory,
  // then turns back for its last frames
  task automatic add_sequence(input int len, input bit drift);
    int k;
    for (k = 0; k < len; k++) begin
      if (drift && k < len - 20) begin
        push_frame(XY_MAX - DX_W'($urandom_range(0, 255)),
                   XY_MIN + DX_W'($urandom_range(0, 255)),
                   DA_W'(DA_LIM - int'($urandom_range(0, 63))), k == len - 1);
      end else if (drift) begin
        push_frame(XY_MIN + DX_W'($urandom_range(0, 255)),
                   XY_MAX - DX_W'($urandom_range(0, 255)),
                   DA_W'(-DA_LIM), k == len - 1);
      end else begin
        push_frame(rand_xy(), rand_xy(), rand_angle(), k == len - 1);
      end
    end
  endtask

  // Stimulus and end of run
  initial begin : stimulus
    int made;
    int len;
    int k;
    bit drift_done;

    // Single-frame sequences, at the extremes and at zero
    push_frame(XY_MAX, XY_MIN, DA_W'(DA_LIM), 1'b1);
    push_frame('0, '0, '0, 1'b1);
    // Two-frame sequence, opposite extremes
    push_frame(XY_MIN, XY_MAX, DA_W'(-DA_LIM), 1'b0);
    push_frame(XY_MAX, XY_MIN, DA_W'(DA_LIM), 1'b1);
    // Angles outside the nominal range, alternating bit patterns
    push_frame(DX_W'(1), DX_W'(-1), A_RAW_MIN, 1'b0);
    push_frame(DX_W'(-1), DX_W'(1), A_RAW_MAX, 1'b0);
    push_frame(DX_W'(24'h555555), DX_W'(24'haaaaaa), DA_W'(19'h2aaaa), 1'b1);
    // Steady ramp: the clipped window pushes the early outputs into saturation
    for (k = 0; k < 4; k++) begin
      push_frame(XY_MAX, XY_MIN, A_RAW_MAX, k == 3);
    end

    // Random sequences, one long drift among them
    made       = 0;
    drift_done = 1'b0;
    while (made < RANDOM_ITEMS) begin
      if (!drift_done && made >= 60) begin
        len = $urandom_range(290, 310);
        add_sequence(len, 1'b1);
        drift_done = 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: len = $urandom_range(1, RADIUS);
          3: begin
            case ($urandom_range(0, 4))
              0:       len = RADIUS - 1;
              1:       len = RADIUS;
              2:       len = RADIUS + 1;
              3:       len = 2 * RADIUS;
              default: len = 2 * RADIUS + 1;
            endcase
          end
          default: len = $urandom_range(RADIUS + 2, 2 * RADIUS + 8);
        endcase
        add_sequence(len, 1'b0);
      end
      made += len;
    end
    planned = pending_frames.size();

    // Drain: all frames sent, all results back, then a quiet stretch
    while (frames_sent != planned) @(posedge clk);
    while (expected_corr.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
